### design/erot_pkg.sv
// ----------------------------------------------------------------------------
// erot_pkg
// Types, constants and functions shared by the 3D Euler rotation block.
// ----------------------------------------------------------------------------
package erot_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int ANGLE_BITS      = 16;
    localparam int CORDIC_STEPS    = 30;
    localparam int COORD_W         = 32;
    localparam int WIDE_W          = 36;   // unsaturated coordinate between planes
    localparam int TRIG_W          = 32;   // Q2.30, range [-2^30, 2^30]
    localparam int PROD_W          = WIDE_W + TRIG_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int CRD_W           = 34;   // CORDIC x, y, z
    localparam int STEP_W          = 5;
    localparam int NUM_ANGLES      = 3;
    localparam int IDX_W           = 2;
    localparam int PADDR_W         = 4;
    localparam int NUM_STAGES      = 7;

    localparam logic signed [CRD_W-1:0]  GAIN_INV  = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 32'sd1073741824;
    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(64'sd536870912);

    localparam logic [IDX_W-1:0] REG_ANGLE_Z = 2'd0;
    localparam logic [IDX_W-1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_ANGLE_X = 2'd2;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [CRD_W-1:0]  t_crd;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_IDLE
    } t_trig_state;

    // atan(2^-i), 2^32 per turn
    function automatic t_crd atan_turns(input logic [STEP_W-1:0] i);
        t_crd v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41721;
            5'd15: v = 34'sd20860;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2607;
            5'd19: v = 34'sd1303;
            5'd20: v = 34'sd651;
            5'd21: v = 34'sd325;
            5'd22: v = 34'sd162;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd40;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd2;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_trig clamp_trig(input t_crd v);
        t_trig r;
        if (v > t_crd'(TRIG_ONE)) begin
            r = TRIG_ONE;
        end else if (v < -t_crd'(TRIG_ONE)) begin
            r = -TRIG_ONE;
        end else begin
            r = TRIG_W'(v);
        end
        return r;
    endfunction

    function automatic t_wide round_q30(input t_prod p0, input t_prod p1, input logic neg);
        logic signed [SUM_W-1:0] s;
        if (neg) begin
            s = SUM_W'(p0) - SUM_W'(p1);
        end else begin
            s = SUM_W'(p0) + SUM_W'(p1);
        end
        s = (s + ROUND_HALF) >>> 30;
        return s[WIDE_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input t_wide v);
        logic [COORD_W-1:0] r;
        if (v > t_wide'(64'sd2147483647)) begin
            r = 32'h7FFF_FFFF;
        end else if (v < t_wide'(-64'sd2147483648)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/erot_if.sv
// ----------------------------------------------------------------------------
// erot_in_if / erot_out_if
// Point request channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface erot_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        last_in_set;

    modport source (output valid, coord_x, coord_y, coord_z, last_in_set, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_in_set, output ready);
endinterface

interface erot_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rotated_x;
    logic [31:0] rotated_y;
    logic [31:0] rotated_z;
    logic        last_out;

    modport source (output valid, rotated_x, rotated_y, rotated_z, last_out, input ready);
    modport sink   (input valid, rotated_x, rotated_y, rotated_z, last_out, output ready);
endinterface

### design/euler_point_rotation_3d_core.sv
// ----------------------------------------------------------------------------
// euler_point_rotation_3d_core
// Rotates a 3D point about z, then y, then x by programmable binary angles.
// ----------------------------------------------------------------------------
// Pipeline: a multiply and an add register per plane, then a saturate register.
// One point per cycle while the CORDIC is idle; a stage stalls only behind a full stage.
// After reset and after every angle write, a shared CORDIC builds cos/sin for all
// three angles in turn; no request is taken until it has finished.
// Reset clears the angles to zero and empties the pipeline.
module euler_point_rotation_3d_core
    import erot_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    erot_in_if.sink            i_pt,
    erot_out_if.source         o_pt,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------- configuration ----------------
    logic [ANGLE_BITS-1:0] r_angle [NUM_ANGLES];
    logic                  w_cfg_wr;
    logic [IDX_W-1:0]      w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ANGLES; k++) r_angle[k] <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ANGLE_Z: r_angle[0] <= pwdata[ANGLE_BITS-1:0];
                REG_ANGLE_Y: r_angle[1] <= pwdata[ANGLE_BITS-1:0];
                REG_ANGLE_X: r_angle[2] <= pwdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ANGLE_Z: prdata = 32'(r_angle[0]);
            REG_ANGLE_Y: prdata = 32'(r_angle[1]);
            REG_ANGLE_X: prdata = 32'(r_angle[2]);
            default:     prdata = '0;
        endcase
    end

    // ---------------- trig sequencer ----------------
    t_trig_state         r_state, n_state;
    logic [IDX_W-1:0]    r_tidx;
    logic [STEP_W-1:0]   r_step;
    logic [1:0]          r_quad;
    t_crd                r_cx, r_cy, r_cz;
    t_trig               r_cos [NUM_ANGLES];
    t_trig               r_sin [NUM_ANGLES];
    logic                w_busy;
    logic                w_last_step;
    logic [31:0]         w_a32;
    logic [1:0]          w_quad;
    logic [31:0]         w_ru;
    t_crd                w_nx, w_ny, w_nz, w_cc, w_ss;

    assign w_last_step = (r_step == STEP_W'(CORDIC_STEPS - 1));
    assign w_a32  = {r_angle[r_tidx], (32 - ANGLE_BITS)'(0)};
    assign w_quad = w_a32[31:30] + 2'(w_a32[29]);
    assign w_ru   = w_a32 - {w_quad, 30'd0};

    always_comb begin
        n_state = r_state;
        if (w_cfg_wr) begin
            n_state = ST_LOAD;
        end else begin
            case (r_state)
                ST_LOAD: n_state = ST_RUN;
                ST_RUN:  n_state = (w_last_step && r_tidx == REG_ANGLE_X) ? ST_IDLE : ST_LOAD;
                ST_IDLE: n_state = ST_IDLE;
                default: n_state = ST_LOAD;
            endcase
            if (r_state == ST_RUN && !w_last_step) n_state = ST_RUN;
        end
    end

    always_comb begin
        w_busy = (r_state != ST_IDLE);
    end

    always_comb begin
        if (!r_cz[CRD_W-1]) begin
            w_nx = r_cx - (r_cy >>> r_step);
            w_ny = r_cy + (r_cx >>> r_step);
            w_nz = r_cz - atan_turns(r_step);
        end else begin
            w_nx = r_cx + (r_cy >>> r_step);
            w_ny = r_cy - (r_cx >>> r_step);
            w_nz = r_cz + atan_turns(r_step);
        end
        case (r_quad)
            2'd0:    begin w_cc = w_nx;  w_ss = w_ny;  end
            2'd1:    begin w_cc = -w_ny; w_ss = w_nx;  end
            2'd2:    begin w_cc = -w_nx; w_ss = -w_ny; end
            default: begin w_cc = w_ny;  w_ss = -w_nx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_tidx  <= REG_ANGLE_Z;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_tidx <= REG_ANGLE_Z;
                r_step <= '0;
            end else if (r_state == ST_RUN) begin
                r_step <= w_last_step ? '0 : r_step + 1'b1;
                if (w_last_step && r_tidx != REG_ANGLE_X) r_tidx <= r_tidx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_cx   <= GAIN_INV;
            r_cy   <= '0;
            r_cz   <= CRD_W'($signed(w_ru));
            r_quad <= w_quad;
        end else if (r_state == ST_RUN) begin
            r_cx <= w_nx;
            r_cy <= w_ny;
            r_cz <= w_nz;
            if (w_last_step) begin
                r_cos[r_tidx] <= clamp_trig(w_cc);
                r_sin[r_tidx] <= clamp_trig(w_ss);
            end
        end
    end

    // ---------------- point pipeline ----------------
    logic  r_v [NUM_STAGES];
    logic  w_en [NUM_STAGES];
    t_prod r_pac [3], r_pbs [3], r_pas [3], r_pbc [3];
    t_wide r_pt  [3];            // coordinate passing beside each multiply stage
    t_wide r_sa [3], r_sb [3], r_sc [3];   // x, y, z after each plane
    logic  r_lst [NUM_STAGES];
    logic [COORD_W-1:0] r_ox, r_oy, r_oz;
    t_wide w_a [3], w_b [3], w_t [3];

    always_comb begin
        w_en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || o_pt.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) w_en[k] = !r_v[k] || w_en[k+1];
    end

    assign i_pt.ready = w_en[0] && !w_busy;

    // plane z: (x,y), plane y: (z,x), plane x: (y,z)
    assign w_a[0] = t_wide'($signed(i_pt.coord_x));
    assign w_b[0] = t_wide'($signed(i_pt.coord_y));
    assign w_t[0] = t_wide'($signed(i_pt.coord_z));
    assign w_a[1] = r_sc[0];
    assign w_b[1] = r_sa[0];
    assign w_t[1] = r_sb[0];
    assign w_a[2] = r_sb[1];
    assign w_b[2] = r_sc[1];
    assign w_t[2] = r_sa[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STAGES; k++) r_v[k] <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= i_pt.valid && !w_busy;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < 3; p++) begin
            if (w_en[2*p]) begin
                r_pac[p]     <= PROD_W'(w_a[p] * r_cos[p]);
                r_pbs[p]     <= PROD_W'(w_b[p] * r_sin[p]);
                r_pas[p]     <= PROD_W'(w_a[p] * r_sin[p]);
                r_pbc[p]     <= PROD_W'(w_b[p] * r_cos[p]);
                r_pt[p]      <= w_t[p];
            end
            if (w_en[2*p+1]) begin
                r_lst[2*p+1] <= r_lst[2*p];
            end
        end
        if (w_en[0]) r_lst[0] <= i_pt.last_in_set;
        if (w_en[2]) r_lst[2] <= r_lst[1];
        if (w_en[4]) r_lst[4] <= r_lst[3];
        if (w_en[1]) begin
            r_sa[0] <= round_q30(r_pac[0], r_pbs[0], 1'b1);
            r_sb[0] <= round_q30(r_pas[0], r_pbc[0], 1'b0);
            r_sc[0] <= r_pt[0];
        end
        if (w_en[3]) begin
            r_sc[1] <= round_q30(r_pac[1], r_pbs[1], 1'b1);
            r_sa[1] <= round_q30(r_pas[1], r_pbc[1], 1'b0);
            r_sb[1] <= r_pt[1];
        end
        if (w_en[5]) begin
            r_sb[2] <= round_q30(r_pac[2], r_pbs[2], 1'b1);
            r_sc[2] <= round_q30(r_pas[2], r_pbc[2], 1'b0);
            r_sa[2] <= r_pt[2];
        end
        if (w_en[6]) begin
            r_ox         <= sat32(r_sa[2]);
            r_oy         <= sat32(r_sb[2]);
            r_oz         <= sat32(r_sc[2]);
            r_lst[6]     <= r_lst[5];
        end
    end

    assign o_pt.valid     = r_v[NUM_STAGES-1];
    assign o_pt.rotated_x = r_ox;
    assign o_pt.rotated_y = r_oy;
    assign o_pt.rotated_z = r_oz;
    assign o_pt.last_out  = r_lst[NUM_STAGES-1];

endmodule

### design/erot_checker.sv
// ----------------------------------------------------------------------------
// erot_checker
// Port-level checks for the 3D Euler rotation block.
// ----------------------------------------------------------------------------
module erot_checker
    import erot_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x,
    input logic        i_pready,
    input logic [31:0] i_prdata
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");

    a_prdata_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_prdata[31:ANGLE_BITS] == '0)
        else $error("angle readback wider than angle");

endmodule

bind euler_point_rotation_3d_core erot_checker u_erot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_out_x     (o_pt.rotated_x),
    .i_pready    (pready),
    .i_prdata    (prdata)
);

### tb/euler_point_rotation_3d_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_point_rotation_3d_core_tb
// Drives random and corner points through the Z-Y-X rotation core under
// several angle settings and compares each rotated point with a local
// CORDIC-based prediction.
// ----------------------------------------------------------------------------
module euler_point_rotation_3d_core_tb;
    import erot_pkg::*;

    typedef struct {
        logic [31:0] x, y, z;
        logic        last;
    } t_point;

    class rotation_scoreboard;
        t_point pending[$];
        int     errors;
        logic [15:0] ang [NUM_ANGLES] = '{default: '0};

        static function longint shr_floor(longint v, int n);
            return v >>> n;
        endfunction

        function void trig(logic [15:0] a, output longint c, output longint s);
            logic [31:0] a32, ru;
            logic [1:0]  q;
            longint      x, y, z, nx, ny, cc, ss;
            a32 = {a, 16'h0};
            q = 2'((a32 + 32'h2000_0000) >> 30);
            ru = a32 - (32'(q) << 30);
            z = longint'($signed(ru));
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - shr_floor(y, i);
                    ny = y + shr_floor(x, i);
                    z -= longint'(atan_turns(5'(i)));
                end else begin
                    nx = x + shr_floor(y, i);
                    ny = y - shr_floor(x, i);
                    z += longint'(atan_turns(5'(i)));
                end
                x = nx;
                y = ny;
            end
            case (q)
                2'd0: begin cc = x; ss = y; end
                2'd1: begin cc = -y; ss = x; end
                2'd2: begin cc = -x; ss = -y; end
                default: begin cc = y; ss = -x; end
            endcase
            c = cc > 1073741824 ? 1073741824 : (cc < -1073741824 ? -1073741824 : cc);
            s = ss > 1073741824 ? 1073741824 : (ss < -1073741824 ? -1073741824 : ss);
        endfunction

        function void turn(ref longint a, ref longint b, input logic [15:0] ang_v);
            longint c, s, pa, pb;
            trig(ang_v, c, s);
            pa = a * c - b * s;
            pb = a * s + b * c;
            a = (pa + 536870912) >>> 30;
            b = (pb + 536870912) >>> 30;
        endfunction

        static function logic [31:0] sat(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function void note_request(t_point p);
            longint x, y, z;
            t_point r;
            x = longint'($signed(p.x));
            y = longint'($signed(p.y));
            z = longint'($signed(p.z));
            turn(x, y, ang[REG_ANGLE_Z]);
            turn(z, x, ang[REG_ANGLE_Y]);
            turn(y, z, ang[REG_ANGLE_X]);
            r.x = sat(x);
            r.y = sat(y);
            r.z = sat(z);
            r.last = p.last;
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("ERR %s got %h want %h at %0t", what, got, want, $time);
        endfunction

        function void check_result(t_point got);
            t_point e;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) report("rotated_x", got.x, e.x);
            if (got.y !== e.y) report("rotated_y", got.y, e.y);
            if (got.z !== e.z) report("rotated_z", got.z, e.z);
            if (got.last !== e.last) report("last_out", 32'(got.last), 32'(e.last));
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    erot_in_if  pt_in();
    erot_out_if pt_out();

    euler_point_rotation_3d_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_in.sink), .o_pt(pt_out.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    rotation_scoreboard sb = new();
    int  idle_pct_in = 20, idle_pct_out = 20;
    bit  hold_out = 0;
    int  quiet = 0;

    initial begin
        pt_in.valid = 0;
        pt_in.coord_x = 0;
        pt_in.coord_y = 0;
        pt_in.coord_z = 0;
        pt_in.last_in_set = 0;
        pt_out.ready = 0;
    end

    always @(posedge i_clk) begin
        if (pt_out.valid && pt_out.ready) begin
            t_point g;
            g.x = pt_out.rotated_x;
            g.y = pt_out.rotated_y;
            g.z = pt_out.rotated_z;
            g.last = pt_out.last_out;
            sb.check_result(g);
        end
        pt_out.ready <= !hold_out && ($urandom_range(99) >= idle_pct_out);
    end

    always @(posedge i_clk) begin
        if ((pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 5000) begin
            $display("euler_point_rotation_3d_core: mismatch");
            $finish;
        end
    end

    task automatic write_angle(logic [IDX_W-1:0] idx, logic [15:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= {16'($urandom_range(65535)), v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.ang[idx] = v;
    endtask

    task automatic send_point(logic [31:0] x, y, z, logic last);
        t_point p;
        while ($urandom_range(99) < idle_pct_in) begin
            pt_in.valid <= 0;
            @(posedge i_clk);
        end
        pt_in.valid <= 1;
        pt_in.coord_x <= x;
        pt_in.coord_y <= y;
        pt_in.coord_z <= z;
        pt_in.last_in_set <= last;
        p.x = x; p.y = y; p.z = z; p.last = last;
        do @(posedge i_clk); while (!pt_in.ready);
        sb.note_request(p);
    endtask

    task automatic drain;
        pt_in.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'($signed($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
    endtask

    logic [15:0] corner_angles[6] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'h2000, 16'hC000};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: reset angles, then corners
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1);
        drain();
        write_angle(REG_ANGLE_Z, 16'h2000);
        write_angle(REG_ANGLE_Y, 16'h4000);
        write_angle(REG_ANGLE_X, 16'hFFFF);
        send_point(32'd0, 32'd0, 32'd0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        drain();
        for (int k = 0; k < 6; k++) begin
            write_angle(REG_ANGLE_Z, corner_angles[k]);
            write_angle(REG_ANGLE_Y, corner_angles[(k + 2) % 6]);
            write_angle(REG_ANGLE_X, corner_angles[(k + 4) % 6]);
            random_points(30);
            drain();
        end
        // backpressure: fill pipeline
        fork
            begin
                hold_out = 1;
                repeat (60) @(posedge i_clk);
                hold_out = 0;
            end
            random_points(40);
        join
        drain();
        idle_pct_in = 0;
        idle_pct_out = 0;
        random_points(120);
        idle_pct_in = 20;
        idle_pct_out = 20;
        drain();
        for (int k = 0; k < 5; k++) begin
            write_angle(REG_ANGLE_Z, 16'($urandom));
            write_angle(REG_ANGLE_Y, 16'($urandom));
            write_angle(REG_ANGLE_X, 16'($urandom));
            random_points(100);
            drain();
        end
        if (sb.errors == 0)
            $display("euler_point_rotation_3d_core: match");
        else
            $display("euler_point_rotation_3d_core: mismatch");
        $finish;
    end
endmodule

### filelist.f
design/erot_pkg.sv
design/erot_if.sv
design/euler_point_rotation_3d_core.sv
design/erot_checker.sv
tb/euler_point_rotation_3d_core_tb.sv
